@@ rtl/core/sssu_pkg.sv @@
// Shared types, constants and the segment lookup for the seven-segment scan serializer.
// Used by the front, queue, back and top level; depends on nothing else.

package sssu_pkg;

   // Digits shown per scan, from units upward.
   localparam int NUM_DIGITS = 8;

   // Bits per serial word: position byte then segment byte.
   localparam int WORD_BITS = 16;
   localparam int BIT_CNT_WIDTH = $clog2(WORD_BITS);

   // One-hot position of the units digit, and the position value that ends a scan.
   localparam logic [7:0] FIRST_POSITION = 8'h80;
   localparam logic [7:0] SCAN_END_MARK =
      (NUM_DIGITS >= 8) ? 8'h00 : 8'(FIRST_POSITION >> NUM_DIGITS);

   // Reciprocal of ten for a 32-bit dividend: q = (v * DIV10_RECIP) >> DIV10_SHIFT.
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;

   // Entries in the queue between the digit front and the serial back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // One digit ready for shifting out.
   typedef struct packed {
      logic [7:0] position_code;
      logic [7:0] segment_pattern;
      logic [3:0] digit_value;
   } sssu_digit_type;

   // Active-low segment pattern of a decimal digit; decimal point always off.
   function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
      logic [7:0] pattern;
      unique case (digit)
         4'd0:    pattern = 8'b1100_0000;
         4'd1:    pattern = 8'b1111_1001;
         4'd2:    pattern = 8'b1010_0100;
         4'd3:    pattern = 8'b1011_0000;
         4'd4:    pattern = 8'b1001_1001;
         4'd5:    pattern = 8'b1001_0010;
         4'd6:    pattern = 8'b1000_0010;
         4'd7:    pattern = 8'b1111_1000;
         4'd8:    pattern = 8'b1000_0000;
         4'd9:    pattern = 8'b1001_1000;
         default: pattern = 8'b1111_1111;
      endcase
      return pattern;
   endfunction

endpackage

@@ rtl/core/sssu_front.sv @@
// Digit front: accepts refresh ticks, tracks the scan, and splits off one decimal digit each.
// Depends on sssu_pkg.

module sssu_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_display_value,
   output logic                    push_valid,
   input  logic                    push_ready,
   output sssu_pkg::sssu_digit_type push_data
);
   import sssu_pkg::*;

   // Scan state.
   logic [7:0]  scan_pos_ff, scan_pos_in;
   logic [31:0] remaining_ff, remaining_in;

   // Stage one: operand of the divide by ten.
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_value_ff, s1_value_in;
   logic [7:0]  s1_pos_ff, s1_pos_in;

   // Stage two: registered reciprocal product.
   logic        s2_valid_ff, s2_valid_in;
   logic [63:0] s2_prod_ff, s2_prod_in;
   logic [31:0] s2_value_ff, s2_value_in;
   logic [7:0]  s2_pos_ff, s2_pos_in;

   logic        accept;
   logic        scan_start;
   logic [7:0]  cur_pos;
   logic [7:0]  next_pos;
   logic [31:0] quotient;
   logic [31:0] times_ten;
   logic [31:0] remainder;
   logic [3:0]  digit;

   // One tick at a time is in the divide; the queue behind it decouples the shifter.
   assign req_ready  = !s1_valid_ff && !s2_valid_ff;
   assign accept     = req_valid && req_ready;
   assign scan_start = (scan_pos_ff == 8'h00);
   assign cur_pos    = scan_start ? FIRST_POSITION : scan_pos_ff;

   always_comb begin
      next_pos = cur_pos >> 1;
      if (next_pos == SCAN_END_MARK) begin
         next_pos = 8'h00;
      end
   end

   assign quotient  = {3'b000, s2_prod_ff[63:DIV10_SHIFT]};
   assign times_ten = (quotient << 3) + (quotient << 1);
   assign remainder = s2_value_ff - times_ten;
   assign digit     = remainder[3:0];

   assign push_valid                = s2_valid_ff;
   assign push_data.position_code   = s2_pos_ff;
   assign push_data.segment_pattern = seg_lookup(digit);
   assign push_data.digit_value     = digit;

   always_comb begin
      scan_pos_in  = scan_pos_ff;
      remaining_in = remaining_ff;
      s1_valid_in  = s1_valid_ff;
      s1_value_in  = s1_value_ff;
      s1_pos_in    = s1_pos_ff;
      s2_valid_in  = s2_valid_ff;
      s2_prod_in   = s2_prod_ff;
      s2_value_in  = s2_value_ff;
      s2_pos_in    = s2_pos_ff;

      if (accept) begin
         scan_pos_in = next_pos;
         s1_valid_in = 1'b1;
         s1_value_in = scan_start ? req_display_value : remaining_ff;
         s1_pos_in   = cur_pos;
      end

      if (s1_valid_ff && !s2_valid_ff) begin
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b1;
         s2_prod_in  = 64'(s1_value_ff) * 64'(DIV10_RECIP);
         s2_value_in = s1_value_ff;
         s2_pos_in   = s1_pos_ff;
      end

      if (s2_valid_ff && push_ready) begin
         s2_valid_in  = 1'b0;
         remaining_in = quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff  <= 8'h00;
         remaining_ff <= 32'h0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         scan_pos_ff  <= scan_pos_in;
         remaining_ff <= remaining_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
      end
      s1_value_ff <= s1_value_in;
      s1_pos_ff   <= s1_pos_in;
      s2_prod_ff  <= s2_prod_in;
      s2_value_ff <= s2_value_in;
      s2_pos_ff   <= s2_pos_in;
   end

endmodule

@@ rtl/core/sssu_queue.sv @@
// Short digit queue between the front and the serial back.
// Depends on sssu_pkg.

module sssu_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  sssu_pkg::sssu_digit_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output sssu_pkg::sssu_digit_type pop_data
);
   import sssu_pkg::*;

   sssu_digit_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]  count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/sssu_back.sv @@
// Serial back: shifts each queued digit word out MSB first, one bit per transfer.
// Depends on sssu_pkg.

module sssu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  sssu_pkg::sssu_digit_type pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_serial_data,
   output logic                    rsp_latch_after,
   output logic [7:0]              rsp_position_code,
   output logic [7:0]              rsp_segment_pattern,
   output logic [3:0]              rsp_digit_value
);
   import sssu_pkg::*;

   logic                      busy_ff, busy_in;
   logic [BIT_CNT_WIDTH-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [WORD_BITS-1:0]      word_ff, word_in;
   sssu_digit_type            digit_ff, digit_in;
   logic                      last_bit;
   logic                      fire;
   logic                      load;

   assign last_bit  = (bit_cnt_ff == BIT_CNT_WIDTH'(WORD_BITS - 1));
   assign fire      = busy_ff && rsp_ready;
   assign pop_ready = !busy_ff || (fire && last_bit);
   assign load      = pop_valid && pop_ready;

   assign rsp_valid           = busy_ff;
   assign rsp_serial_data     = word_ff[WORD_BITS-1];
   assign rsp_latch_after     = last_bit;
   assign rsp_position_code   = digit_ff.position_code;
   assign rsp_segment_pattern = digit_ff.segment_pattern;
   assign rsp_digit_value     = digit_ff.digit_value;

   always_comb begin
      busy_in    = busy_ff;
      bit_cnt_in = bit_cnt_ff;
      word_in    = word_ff;
      digit_in   = digit_ff;
      if (fire) begin
         word_in    = word_ff << 1;
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in    = 1'b1;
         bit_cnt_in = '0;
         word_in    = {pop_data.position_code, pop_data.segment_pattern};
         digit_in   = pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
      end
      word_ff  <= word_in;
      digit_ff <= digit_in;
   end

endmodule

@@ rtl/core/seven_segment_scan_serializer_unit.sv @@
// Seven-segment scan serializer: top level joining the digit front, queue and serial back.
// Depends on sssu_pkg, sssu_front, sssu_queue and sssu_back.
//
// Each transfer on the req_ channel is one refresh tick. The tick that starts a scan
// latches req_display_value; every tick then produces the next decimal digit, units
// first, and leading zeros are shown. After eight digits the next tick starts a new scan.
// For each tick the rsp_ channel delivers sixteen transfers: the one-hot position byte
// and then the active-low segment byte, MSB first, one bit on rsp_serial_data per
// transfer. rsp_latch_after is high on the sixteenth, and position, segment pattern and
// digit stay the same across all sixteen.
// The first bit of a tick is offered after it passes the operand register, the
// reciprocal product register, the queue and the shift register. Throughput: one
// bit per cycle when the receiver never stalls, so the serial shifter sets the rate
// of ticks. The front takes a new tick once its divide stages are empty, and works
// ahead of the shifter while the two-entry queue has room. When the receiver stalls,
// the current bit is held on the ports, the queue fills, and then req_ready drops.
// Reset clears the scan so that the first tick after it latches a fresh number, and
// empties the queue and the shifter.

module seven_segment_scan_serializer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_display_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_serial_data,
   output logic        rsp_latch_after,
   output logic [7:0]  rsp_position_code,
   output logic [7:0]  rsp_segment_pattern,
   output logic [3:0]  rsp_digit_value
);
   import sssu_pkg::*;

   // Front to queue.
   logic           push_valid;
   logic           push_ready;
   sssu_digit_type push_data;

   // Queue to back.
   logic           pop_valid;
   logic           pop_ready;
   sssu_digit_type pop_data;

   // The front owns the scan position and the value still to be shown.
   sssu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_display_value (req_display_value),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_data         (push_data)
   );

   // The queue lets the front finish the next digit while the back is still shifting.
   sssu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The back loads a new word on the same cycle as the last bit of the previous one
   // is taken, so consecutive words leave without a gap.
   sssu_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_serial_data     (rsp_serial_data),
      .rsp_latch_after     (rsp_latch_after),
      .rsp_position_code   (rsp_position_code),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_digit_value     (rsp_digit_value)
   );

endmodule

@@ rtl/core/sssu_checker.sv @@
// Port-level checks for the seven-segment scan serializer, bound to its top level.
// Depends only on the top-level ports.

module sssu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_serial_data,
   input logic       rsp_latch_after,
   input logic [7:0] rsp_position_code,
   input logic [3:0] rsp_digit_value
);

   // Reset leaves no result on offer.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds its bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_serial_data)
         && $stable(rsp_latch_after))
      else $error("stalled result changed");

   // Within one word the next bit follows at once with the same position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_latch_after |=> rsp_valid
         && $stable(rsp_position_code) && $stable(rsp_digit_value))
      else $error("word broken before its last bit");

   // Every offered result carries a one-hot position and a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_position_code) && (rsp_digit_value <= 4'd9))
      else $error("bad position or digit");

endmodule

bind seven_segment_scan_serializer_unit sssu_checker u_sssu_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_serial_data   (rsp_serial_data),
   .rsp_latch_after   (rsp_latch_after),
   .rsp_position_code (rsp_position_code),
   .rsp_digit_value   (rsp_digit_value)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the seven-segment scan serializer unit.
// Needs sssu_pkg and seven_segment_scan_serializer_unit; nothing else is read or loaded.

module tb_top;

   import sssu_pkg::*;

   // No transfer on either channel for this many cycles ends the run as a hang.
   // The slowest correct stretch is the long receiver hold-off below, and this limit
   // leaves a wide margin over it.
   localparam int STALL_LIMIT   = 3000;
   // The receiver stops taking bits for this long once, so that the queue fills
   // and req_ready drops.
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AFTER    = 1500;
   // Cycles allowed after the last expected bit for stray transfers to show up.
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_SCANS  = 22;
   localparam int PRINT_CAP     = 40;

   // One serial bit as the rsp_ channel should present it.
   typedef struct packed {
      logic       serial_data;
      logic       latch_after;
      logic [7:0] position_code;
      logic [7:0] segment_pattern;
      logic [3:0] digit_value;
   } shown_bit_type;

   // One entry for the tick driver. It is either a number to offer or a request
   // to pause until the block has delivered everything.
   typedef struct {
      logic        hold_for_drain;
      logic [31:0] display_value;
   } tick_entry_type;

   // Receiver pacing styles.
   typedef enum logic [1:0] {
      PACE_OPEN,
      PACE_COIN,
      PACE_SPARSE,
      PACE_STRIDE
   } pace_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_display_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_serial_data;
   logic        rsp_latch_after;
   logic [7:0]  rsp_position_code;
   logic [7:0]  rsp_segment_pattern;
   logic [3:0]  rsp_digit_value;

   // Ticks waiting to be offered, and the bits that accepted ticks still owe.
   tick_entry_type tick_backlog[$];
   shown_bit_type  digit_bits_due[$];

   // Copy of the block's scan state, advanced once for every accepted tick.
   logic [7:0]  scan_position;
   logic [31:0] unshown_value;

   // The number of bits still owed, as of the last clock edge. It is written with
   // a nonblocking assignment so that the driver reads the same value whatever
   // order the clocked blocks run in.
   int          bits_outstanding = 0;
   int          bits_checked = 0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;

   // Tick driver state.
   int          burst_left = 0;
   int          gap_left = 0;
   logic        waiting_drain = 1'b0;

   // Receiver pacing state.
   pace_mode_type pace_mode = PACE_OPEN;
   int          pace_left = 0;
   int          stride_phase = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          bits_taken = 0;

   seven_segment_scan_serializer_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_display_value   (req_display_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_serial_data     (rsp_serial_data),
      .rsp_latch_after     (rsp_latch_after),
      .rsp_position_code   (rsp_position_code),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_digit_value     (rsp_digit_value)
   );

   always #6 clock = ~clock;

   // Active-low segment byte of one decimal digit. Bit 7 is the decimal point and
   // always stays off (high).
   function automatic logic [7:0] glyph_for(input logic [3:0] digit);
      case (digit)
         4'd0: return 8'hC0;
         4'd1: return 8'hF9;
         4'd2: return 8'hA4;
         4'd3: return 8'hB0;
         4'd4: return 8'h99;
         4'd5: return 8'h92;
         4'd6: return 8'h82;
         4'd7: return 8'hF8;
         4'd8: return 8'h80;
         4'd9: return 8'h98;
         default: return 8'hFF;
      endcase
   endfunction

   // Advances the scan by one tick and queues the sixteen bits that the tick owes.
   // A tick that finds the scan position at zero latches its number. Every other
   // tick ignores its input. The units digit goes out first, at position 0x80.
   task automatic queue_digit_bits(input logic [31:0] tick_value);
      logic [3:0]    digit;
      logic [7:0]    glyph;
      logic [15:0]   word;
      shown_bit_type one_bit;
      int            k;
      if (scan_position == 8'h00) begin
         scan_position = FIRST_POSITION;
         unshown_value = tick_value;
      end
      digit = 4'(unshown_value % 32'd10);
      unshown_value = unshown_value / 32'd10;
      glyph = glyph_for(digit);
      word = {scan_position, glyph};
      for (k = 0; k < WORD_BITS; k++) begin
         one_bit.serial_data     = word[WORD_BITS - 1 - k];
         one_bit.latch_after     = (k == WORD_BITS - 1);
         one_bit.position_code   = scan_position;
         one_bit.segment_pattern = glyph;
         one_bit.digit_value     = digit;
         digit_bits_due.push_back(one_bit);
      end
      // After the last position of the scan, the next tick latches a new number.
      scan_position = scan_position >> 1;
      if (scan_position == SCAN_END_MARK) begin
         scan_position = 8'h00;
      end
   endtask

   // Prints one line per mismatch, up to a cap, and counts every mismatch.
   task automatic flag_mismatch(input string field_name, input logic [31:0] seen,
                                input logic [31:0] wanted);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("mismatch on bit transfer %0d at %0t: %s is 0x%0h, expected 0x%0h",
                  bits_checked, $realtime, field_name, seen, wanted);
      end
   endtask

   // Picks the number that starts a scan. The mix covers full-range numbers, numbers
   // that fit in eight digits, short numbers with leading zeros, powers of ten and
   // their neighbors, values near the top of the range, and numbers of nine or ten
   // digits whose upper digits must be dropped.
   function automatic logic [31:0] pick_display_value();
      logic [31:0] power;
      int          n;
      power = 32'd1;
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 99999999);
         2: return $urandom_range(0, 999);
         3: begin
            n = $urandom_range(0, 9);
            repeat (n) power = power * 32'd10;
            return power - $urandom_range(0, 1);
         end
         4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return 32'd100000000 * $urandom_range(1, 41) + $urandom_range(0, 99999999);
      endcase
   endfunction

   // Tick driver. It offers ticks from the backlog in bursts of random length with
   // random gaps between them. A pause entry holds it back until every owed bit has
   // come out. A tick that is offered stays on the port until its transfer.
   always @(posedge clock) begin : tick_driver
      tick_entry_type entry;
      logic           offer;
      if (reset) begin
         req_valid <= 1'b0;
         req_display_value <= '0;
         burst_left = $urandom_range(1, 8);
         gap_left = 0;
         waiting_drain = 1'b0;
      end else if (!req_valid || req_ready) begin
         offer = 1'b0;
         entry.hold_for_drain = 1'b0;
         entry.display_value = '0;
         if (waiting_drain) begin
            if (bits_outstanding == 0) begin
               waiting_drain = 1'b0;
            end
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (tick_backlog.size() > 0) begin
            entry = tick_backlog.pop_front();
            if (entry.hold_for_drain) begin
               waiting_drain = 1'b1;
            end else begin
               offer = 1'b1;
               if (burst_left <= 1) begin
                  // Some bursts are long and others short. The gap after a burst is drawn apart
                  // from its length and is zero in about a quarter of cases.
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left--;
               end
            end
         end
         req_valid <= offer;
         // While nothing is offered, the payload carries noise that must not matter.
         req_display_value <= offer ? entry.display_value : 32'($urandom());
      end
   end

   // Receiver. Its ready follows a style that is redrawn at random: always ready, a
   // coin flip, mostly stalled, or a stride that drops ready whenever the stride phase
   // is a multiple of three. Once enough bits have been taken, it holds off for a long
   // stretch, so that the queue fills and the input side stalls while ticks are still offered.
   always @(posedge clock) begin : bit_receiver
      logic take;
      if (reset) begin
         rsp_ready <= 1'b0;
         bits_taken = 0;
         pace_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bits_taken++;
         end
         stride_phase++;
         take = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (!hold_done && bits_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            take = 1'b0;
         end else begin
            if (pace_left == 0) begin
               pace_mode = pace_mode_type'($urandom_range(0, 3));
               pace_left = $urandom_range(16, 96);
            end else begin
               pace_left--;
            end
            case (pace_mode)
               PACE_OPEN:   take = 1'b1;
               PACE_COIN:   take = 1'($urandom_range(0, 1));
               PACE_SPARSE: take = ($urandom_range(0, 3) == 0);
               PACE_STRIDE: take = (stride_phase % 3 != 0);
               default:     take = 1'b1;
            endcase
         end
         rsp_ready <= take;
      end
   end

   // Checker. A tick transfer advances the scan state and queues its bits. A bit
   // transfer is then compared field by field with the oldest owed bit. Ticks are
   // handled first, so the order is fixed within the block.
   always @(posedge clock) begin : bit_checker
      shown_bit_type want;
      if (reset) begin
         scan_position = 8'h00;
         unshown_value = '0;
         digit_bits_due.delete();
         bits_outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            queue_digit_bits(req_display_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (digit_bits_due.size() == 0) begin
               flag_mismatch("unowed bit transfer", 32'd1, 32'd0);
            end else begin
               want = digit_bits_due.pop_front();
               if (rsp_serial_data !== want.serial_data)
                  flag_mismatch("serial_data", 32'(rsp_serial_data),
                                32'(want.serial_data));
               if (rsp_latch_after !== want.latch_after)
                  flag_mismatch("latch_after", 32'(rsp_latch_after),
                                32'(want.latch_after));
               if (rsp_position_code !== want.position_code)
                  flag_mismatch("position_code", 32'(rsp_position_code),
                                32'(want.position_code));
               if (rsp_segment_pattern !== want.segment_pattern)
                  flag_mismatch("segment_pattern", 32'(rsp_segment_pattern),
                                32'(want.segment_pattern));
               if (rsp_digit_value !== want.digit_value)
                  flag_mismatch("digit_value", 32'(rsp_digit_value),
                                32'(want.digit_value));
            end
            bits_checked++;
         end
         bits_outstanding <= digit_bits_due.size();
      end
   end

   // Watchdog. It counts the cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of run.
   initial begin
      int             scan;
      int             k;
      logic [31:0]    start_value;
      tick_entry_type entry;

      entry.hold_for_drain = 1'b0;

      // Directed scans. The first starts right after reset with the largest number,
      // so only its low eight digits show. The next shows all zeros, with all-ones
      // noise on the seven ticks that ignore their input. The third shows 10987654, with
      // every digit but two and three. The in-between ticks carry alternating noise.
      entry.display_value = 32'hFFFF_FFFF;
      tick_backlog.push_back(entry);
      for (k = 0; k < NUM_DIGITS - 1; k++) begin
         entry.display_value = k[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
         tick_backlog.push_back(entry);
      end
      entry.display_value = 32'd0;
      tick_backlog.push_back(entry);
      for (k = 0; k < NUM_DIGITS - 1; k++) begin
         entry.display_value = 32'hFFFF_FFFF;
         tick_backlog.push_back(entry);
      end
      entry.display_value = 32'd10987654;
      tick_backlog.push_back(entry);
      for (k = 0; k < NUM_DIGITS - 1; k++) begin
         entry.display_value = k[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
         tick_backlog.push_back(entry);
      end

      // Pause until the block has delivered every owed bit.
      entry.hold_for_drain = 1'b1;
      tick_backlog.push_back(entry);
      entry.hold_for_drain = 1'b0;

      // Random part. Each scan is a whole one: a starting number, then ticks whose
      // input is random noise. One more pause is placed partway through.
      for (scan = 0; scan < RANDOM_SCANS; scan++) begin
         if (scan == RANDOM_SCANS - 8) begin
            entry.hold_for_drain = 1'b1;
            tick_backlog.push_back(entry);
            entry.hold_for_drain = 1'b0;
         end
         start_value = pick_display_value();
         entry.display_value = start_value;
         tick_backlog.push_back(entry);
         for (k = 0; k < NUM_DIGITS - 1; k++) begin
            entry.display_value = $urandom();
            tick_backlog.push_back(entry);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait at the falling edge, where every clocked update has settled, until
      // every tick has been taken and every owed bit has come out.
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_valid || bits_outstanding != 0);

      // Give stray bit transfers time to appear before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/sssu_pkg.sv
rtl/core/sssu_front.sv
rtl/core/sssu_queue.sv
rtl/core/sssu_back.sv
rtl/core/seven_segment_scan_serializer_unit.sv
rtl/core/sssu_checker.sv
bench/tb_top.sv
